/* hw/rtl/dlg_pkg.sv */
// Shared types, constants and helper functions for the layer geometry block.
// Used by every module under hw/rtl; no dependencies of its own.
package dlg_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIM_BITS   = 14;
  localparam int IW         = (COORD_BITS > DIM_BITS ? COORD_BITS : DIM_BITS) + 4;
  localparam int PROD_BITS  = 2 * DIM_BITS;
  localparam int DIV_STAGES = DIM_BITS;
  localparam int MQ_DEPTH   = 4;
  localparam int MQ_AW      = $clog2(MQ_DEPTH);
  localparam int MQ_CW      = $clog2(MQ_DEPTH + 1);
  localparam int OUT_DEPTH  = 32;
  localparam int OUT_AW     = $clog2(OUT_DEPTH);
  localparam int OUT_CW     = $clog2(OUT_DEPTH + 1);

  localparam logic [1:0] REG_SCREEN_W   = 2'd0;
  localparam logic [1:0] REG_SCREEN_H   = 2'd1;
  localparam logic [1:0] REG_SCREEN_ROT = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic signed [IW-1:0]  crd_t;
  typedef logic [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    dim_t       w;
    dim_t       h;
    logic [1:0] rot;
  } cfg_t;

  typedef struct packed {
    crd_t       dx;
    crd_t       dy;
    dim_t       dw;
    dim_t       dh;
    dim_t       sx;
    dim_t       sy;
    dim_t       sw;
    dim_t       sh;
    logic [1:0] xform;
    logic       crop;
    logic       disp;
  } rot_t;

  typedef struct packed {
    crd_t       dx;
    crd_t       dy;
    dim_t       dw;
    dim_t       dh;
    dim_t       odw;
    dim_t       odh;
    dim_t       ox;
    dim_t       oy;
    dim_t       sx;
    dim_t       sy;
    dim_t       sw;
    dim_t       sh;
    logic [1:0] xform;
    logic       crop;
    logic       rescale;
    logic       res_empty;
    logic       dst_empty;
  } mid_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] dst_x;
    logic [COORD_BITS-1:0] dst_y;
    dim_t                  dst_w;
    dim_t                  dst_h;
    dim_t                  src_x;
    dim_t                  src_y;
    dim_t                  src_w;
    dim_t                  src_h;
    logic [1:0]            xform;
  } res_t;

  typedef struct packed {
    dim_t rem;
    dim_t lo;
    dim_t q;
    dim_t den;
  } dv_t;

  function automatic dv_t div_step(dv_t a);
    dv_t                 o;
    logic [DIM_BITS:0]   r;
    logic                ge;
    r     = {a.rem, a.lo[DIM_BITS-1]};
    ge    = (r >= {1'b0, a.den});
    o.den = a.den;
    o.rem = ge ? DIM_BITS'(r - {1'b0, a.den}) : r[DIM_BITS-1:0];
    o.lo  = {a.lo[DIM_BITS-2:0], 1'b0};
    o.q   = {a.q[DIM_BITS-2:0], ge};
    return o;
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_coord(crd_t v);
    crd_t hi;
    crd_t lo;
    hi = crd_t'((longint'(1) << (COORD_BITS - 1)) - 1);
    lo = -hi - crd_t'(1);
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/dlg_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dlg_pkg (dv_t, div_step). Quotient must fit DIM_BITS.
module dlg_div (
  input  logic           clk,
  input  dlg_pkg::prod_t num,
  input  dlg_pkg::dim_t  den,
  output dlg_pkg::dim_t  q
);

  dlg_pkg::dv_t st_r [dlg_pkg::DIV_STAGES];
  dlg_pkg::dv_t init;

  always_comb begin
    init.rem = num[dlg_pkg::PROD_BITS-1:dlg_pkg::DIM_BITS];
    init.lo  = num[dlg_pkg::DIM_BITS-1:0];
    init.q   = '0;
    init.den = den;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= dlg_pkg::div_step(init);
    for (int k = 1; k < dlg_pkg::DIV_STAGES; k++) begin
      st_r[k] <= dlg_pkg::div_step(st_r[k-1]);
    end
  end

  assign q = st_r[dlg_pkg::DIV_STAGES-1].q;

endmodule

/* hw/rtl/dlg_front.sv */
// Front end: accepts words, rotates the destination, clips it to the panel
// and classifies the rescale case. Depends on dlg_pkg.
module dlg_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dlg_pkg::cfg_t                       cfg,
  input  logic                                push,
  output logic                                full,
  input  logic signed [dlg_pkg::COORD_BITS-1:0] in_dst_x,
  input  logic signed [dlg_pkg::COORD_BITS-1:0] in_dst_y,
  input  dlg_pkg::dim_t                       in_dst_w,
  input  dlg_pkg::dim_t                       in_dst_h,
  input  dlg_pkg::dim_t                       in_src_x,
  input  dlg_pkg::dim_t                       in_src_y,
  input  dlg_pkg::dim_t                       in_src_w,
  input  dlg_pkg::dim_t                       in_src_h,
  input  logic [1:0]                          in_surface_rotation,
  input  logic                                in_scale_crop_mode,
  input  logic                                in_is_display_layer,
  output logic                                mq_push,
  output dlg_pkg::mid_t                       mq_din,
  input  logic                                mq_full
);

  logic          en;
  logic          f1_v_r;
  logic          f2_v_r;
  dlg_pkg::rot_t f1_r;
  dlg_pkg::rot_t rot;
  dlg_pkg::mid_t f2_r;
  dlg_pkg::mid_t mid;

  dlg_pkg::crd_t x, y, w, h, bw, bh;
  dlg_pkg::crd_t l, t, ex, ey, rx, ry, cw, ch, offx, offy;
  logic          clip_empty;
  logic          changed;
  dlg_pkg::crd_t lf, tf;
  dlg_pkg::dim_t cwf, chf;

  assign en      = !f2_v_r || !mq_full;
  assign full    = !en;
  assign mq_push = f2_v_r && !mq_full;
  assign mq_din  = f2_r;

  always_comb begin
    x  = dlg_pkg::crd_t'(in_dst_x);
    y  = dlg_pkg::crd_t'(in_dst_y);
    w  = dlg_pkg::crd_t'(in_dst_w);
    h  = dlg_pkg::crd_t'(in_dst_h);
    bw = dlg_pkg::crd_t'(cfg.w);
    bh = dlg_pkg::crd_t'(cfg.h);
    rot.sx    = in_src_x;
    rot.sy    = in_src_y;
    rot.sw    = in_src_w;
    rot.sh    = in_src_h;
    rot.xform = 2'(2'd0 - cfg.rot - in_surface_rotation);
    rot.crop  = in_scale_crop_mode && !in_is_display_layer;
    rot.disp  = in_is_display_layer;
    unique case (cfg.rot)
      dlg_pkg::ROT_90: begin
        rot.dx = y;          rot.dy = bh - x - w; rot.dw = in_dst_h; rot.dh = in_dst_w;
      end
      dlg_pkg::ROT_180: begin
        rot.dx = bw - x - w; rot.dy = bh - y - h; rot.dw = in_dst_w; rot.dh = in_dst_h;
      end
      dlg_pkg::ROT_270: begin
        rot.dx = bw - y - h; rot.dy = x;          rot.dw = in_dst_h; rot.dh = in_dst_w;
      end
      default: begin
        rot.dx = x;          rot.dy = y;          rot.dw = in_dst_w; rot.dh = in_dst_h;
      end
    endcase
  end

  always_comb begin
    l  = (f1_r.dx < 0) ? '0 : f1_r.dx;
    t  = (f1_r.dy < 0) ? '0 : f1_r.dy;
    ex = f1_r.dx + dlg_pkg::crd_t'(f1_r.dw);
    ey = f1_r.dy + dlg_pkg::crd_t'(f1_r.dh);
    rx = (ex < bw) ? ex : bw;
    ry = (ey < bh) ? ey : bh;
    cw = rx - l;
    ch = ry - t;
    clip_empty = (cw <= 0) || (ch <= 0);
    lf  = clip_empty ? '0 : l;
    tf  = clip_empty ? '0 : t;
    cwf = clip_empty ? '0 : cw[dlg_pkg::DIM_BITS-1:0];
    chf = clip_empty ? '0 : ch[dlg_pkg::DIM_BITS-1:0];
    offx = lf - f1_r.dx;
    offy = tf - f1_r.dy;
    changed = !(lf == f1_r.dx && tf == f1_r.dy && cwf == f1_r.dw && chf == f1_r.dh);

    mid.odw       = f1_r.dw;
    mid.odh       = f1_r.dh;
    mid.ox        = clip_empty ? '0 : offx[dlg_pkg::DIM_BITS-1:0];
    mid.oy        = clip_empty ? '0 : offy[dlg_pkg::DIM_BITS-1:0];
    mid.sx        = f1_r.sx;
    mid.sy        = f1_r.sy;
    mid.sw        = f1_r.sw;
    mid.sh        = f1_r.sh;
    mid.xform     = f1_r.xform;
    mid.crop      = f1_r.crop;
    mid.res_empty = (cwf == '0) || (chf == '0);
    mid.dst_empty = (f1_r.dw == '0) || (f1_r.dh == '0);
    mid.rescale   = !f1_r.disp && changed;
    if (mid.rescale) begin
      mid.dx = lf;      mid.dy = tf;      mid.dw = cwf;     mid.dh = chf;
    end else begin
      mid.dx = f1_r.dx; mid.dy = f1_r.dy; mid.dw = f1_r.dw; mid.dh = f1_r.dh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= push;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= rot;
      f2_r <= mid;
    end
  end

endmodule

/* hw/rtl/dlg_mq.sv */
// Short word queue between the front end and the arithmetic back end.
// Depends on dlg_pkg (mid_t, queue depth).
module dlg_mq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dlg_pkg::mid_t din,
  output logic          full,
  input  logic          pop,
  output logic          vld,
  output dlg_pkg::mid_t dout
);

  dlg_pkg::mid_t                mem_r [dlg_pkg::MQ_DEPTH];
  logic [dlg_pkg::MQ_AW-1:0]    wp_r, rp_r;
  logic [dlg_pkg::MQ_CW-1:0]    cnt_r;

  assign full = (cnt_r == dlg_pkg::MQ_CW'(dlg_pkg::MQ_DEPTH));
  assign vld  = (cnt_r != '0);
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + dlg_pkg::MQ_CW'(push) - dlg_pkg::MQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule

/* hw/rtl/dlg_back.sv */
// Back end: source rescale and scale-crop trim on pipelined dividers, then
// saturation into the result queue. Depends on dlg_pkg and dlg_div.
module dlg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          mq_vld,
  input  dlg_pkg::mid_t mq_dout,
  output logic          mq_pop,
  input  logic          pop,
  output logic          empty,
  output dlg_pkg::res_t head
);

  typedef struct packed {
    dlg_pkg::mid_t m;
    logic          gt;
    logic          lt;
  } sb_t;

  localparam int NS = dlg_pkg::DIV_STAGES;

  logic [dlg_pkg::OUT_CW-1:0] crd_r;
  logic                       issue;
  logic                       deq;

  logic                       p_v_r;
  dlg_pkg::mid_t              p_m_r;
  dlg_pkg::prod_t             p_nx_r, p_ny_r, p_nw_r, p_nh_r;
  dlg_pkg::dim_t              qx, qy, qw, qh;

  logic                       s1_v_r [NS];
  dlg_pkg::mid_t              s1_m_r [NS];
  dlg_pkg::mid_t              m1;

  logic                       c_v_r;
  dlg_pkg::mid_t              c_m_r;
  dlg_pkg::prod_t             c_lhs_r, c_rhs_r;
  logic                       c_gt, c_lt;
  dlg_pkg::prod_t             c_num;
  dlg_pkg::dim_t              c_den;
  dlg_pkg::dim_t              qc;

  logic                       s2_v_r [NS];
  sb_t                        s2_r   [NS];
  sb_t                        f;
  dlg_pkg::res_t              res;
  logic [dlg_pkg::DIM_BITS:0] sum;

  dlg_pkg::res_t              mem_r [dlg_pkg::OUT_DEPTH];
  logic [dlg_pkg::OUT_AW-1:0] wp_r, rp_r;
  logic [dlg_pkg::OUT_CW-1:0] cnt_r;
  logic                       wr;

  assign issue  = mq_vld && (crd_r < dlg_pkg::OUT_CW'(dlg_pkg::OUT_DEPTH));
  assign mq_pop = issue;
  assign empty  = (cnt_r == '0);
  assign deq    = pop && !empty;
  assign head   = mem_r[rp_r];
  assign wr     = s2_v_r[NS-1];

  always_ff @(posedge clk) begin
    p_m_r  <= mq_dout;
    p_nx_r <= mq_dout.ox * mq_dout.sw;
    p_ny_r <= mq_dout.oy * mq_dout.sh;
    p_nw_r <= mq_dout.sw * mq_dout.dw;
    p_nh_r <= mq_dout.sh * mq_dout.dh;
  end

  dlg_div u_div_x (.clk(clk), .num(p_nx_r), .den(p_m_r.odw), .q(qx));
  dlg_div u_div_y (.clk(clk), .num(p_ny_r), .den(p_m_r.odh), .q(qy));
  dlg_div u_div_w (.clk(clk), .num(p_nw_r), .den(p_m_r.odw), .q(qw));
  dlg_div u_div_h (.clk(clk), .num(p_nh_r), .den(p_m_r.odh), .q(qh));

  always_ff @(posedge clk) begin
    s1_m_r[0] <= p_m_r;
    for (int k = 1; k < NS; k++) s1_m_r[k] <= s1_m_r[k-1];
  end

  always_comb begin
    m1 = s1_m_r[NS-1];
    if (m1.rescale) begin
      m1.sx = m1.res_empty ? '0 : qx;
      m1.sy = m1.res_empty ? '0 : qy;
      m1.sw = m1.dst_empty ? '0 : qw;
      m1.sh = m1.dst_empty ? '0 : qh;
    end
  end

  always_ff @(posedge clk) begin
    c_m_r   <= m1;
    c_lhs_r <= m1.sw * m1.dh;
    c_rhs_r <= m1.sh * m1.dw;
  end

  // nw = dw*sh/dh, nh = dh*sw/dw
  always_comb begin
    c_gt  = c_lhs_r > c_rhs_r;
    c_lt  = c_lhs_r < c_rhs_r;
    c_num = c_gt ? c_rhs_r : c_lhs_r;
    c_den = c_gt ? c_m_r.dh : c_m_r.dw;
  end

  dlg_div u_div_c (.clk(clk), .num(c_num), .den(c_den), .q(qc));

  always_ff @(posedge clk) begin
    s2_r[0] <= '{m: c_m_r, gt: c_gt, lt: c_lt};
    for (int k = 1; k < NS; k++) s2_r[k] <= s2_r[k-1];
  end

  always_comb begin
    f   = s2_r[NS-1];
    sum = '0;
    res.src_x = f.m.sx;
    res.src_y = f.m.sy;
    res.src_w = f.m.sw;
    res.src_h = f.m.sh;
    if (f.m.crop && f.gt) begin
      sum       = {1'b0, f.m.sx} + {2'b0, 13'((f.m.sw - qc) >> 1)};
      res.src_x = sum[dlg_pkg::DIM_BITS] ? '1 : sum[dlg_pkg::DIM_BITS-1:0];
      res.src_w = qc;
    end else if (f.m.crop && f.lt) begin
      sum       = {1'b0, f.m.sy} + {2'b0, 13'((f.m.sh - qc) >> 1)};
      res.src_y = sum[dlg_pkg::DIM_BITS] ? '1 : sum[dlg_pkg::DIM_BITS-1:0];
      res.src_h = qc;
    end
    res.dst_x = dlg_pkg::sat_coord(f.m.dx);
    res.dst_y = dlg_pkg::sat_coord(f.m.dy);
    res.dst_w = f.m.dw;
    res.dst_h = f.m.dh;
    res.xform = f.m.xform;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      c_v_r <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        s1_v_r[k] <= 1'b0;
        s2_v_r[k] <= 1'b0;
      end
      crd_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      p_v_r     <= issue;
      s1_v_r[0] <= p_v_r;
      c_v_r     <= s1_v_r[NS-1];
      s2_v_r[0] <= c_v_r;
      for (int k = 1; k < NS; k++) begin
        s1_v_r[k] <= s1_v_r[k-1];
        s2_v_r[k] <= s2_v_r[k-1];
      end
      crd_r <= crd_r + dlg_pkg::OUT_CW'(issue) - dlg_pkg::OUT_CW'(deq);
      if (wr)  wp_r <= wp_r + 1'b1;
      if (deq) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + dlg_pkg::OUT_CW'(wr) - dlg_pkg::OUT_CW'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= res;
  end

endmodule

/* hw/rtl/display_layer_geometry.sv */
// Top level of the layer geometry block: configuration registers, front end,
// word queue and back end. Depends on dlg_pkg, dlg_front, dlg_mq, dlg_back.
//
// Usage:
//   Input words are accepted at a clock edge with push high and full low.
//   Results come out in order: while empty is low the oldest result sits on
//   the out_ ports and is taken at an edge with pop high.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr
//   (0 screen width, 1 screen height, 2 screen rotation); other indexes are
//   ignored. Write only while no word is in flight.
//   A word passes from the accepting edge to the first edge at which its
//   result can be popped through two front stages, the queue, a multiply
//   stage, two 14-stage divider pipelines with a compare stage between them
//   and the result queue write.
//   Throughput: one word per cycle while full is low.
//   Reset (rst_n low, synchronous) empties all queues and loads 1920 x 1080,
//   rotation 0. When the receiver stops popping, the 32-entry result queue
//   fills, the back end stops taking words, the middle queue fills and full
//   rises; nothing is dropped.
module display_layer_geometry (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_addr,
  input  logic [dlg_pkg::DIM_BITS-1:0]          cfg_wdata,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [dlg_pkg::COORD_BITS-1:0] in_dst_x,
  input  logic signed [dlg_pkg::COORD_BITS-1:0] in_dst_y,
  input  logic [dlg_pkg::DIM_BITS-1:0]          in_dst_w,
  input  logic [dlg_pkg::DIM_BITS-1:0]          in_dst_h,
  input  logic [dlg_pkg::DIM_BITS-1:0]          in_src_x,
  input  logic [dlg_pkg::DIM_BITS-1:0]          in_src_y,
  input  logic [dlg_pkg::DIM_BITS-1:0]          in_src_w,
  input  logic [dlg_pkg::DIM_BITS-1:0]          in_src_h,
  input  logic [1:0]                            in_surface_rotation,
  input  logic                                  in_scale_crop_mode,
  input  logic                                  in_is_display_layer,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [dlg_pkg::COORD_BITS-1:0] out_dst_x,
  output logic signed [dlg_pkg::COORD_BITS-1:0] out_dst_y,
  output logic [dlg_pkg::DIM_BITS-1:0]          out_dst_w,
  output logic [dlg_pkg::DIM_BITS-1:0]          out_dst_h,
  output logic [dlg_pkg::DIM_BITS-1:0]          out_src_x,
  output logic [dlg_pkg::DIM_BITS-1:0]          out_src_y,
  output logic [dlg_pkg::DIM_BITS-1:0]          out_src_w,
  output logic [dlg_pkg::DIM_BITS-1:0]          out_src_h,
  output logic [1:0]                            out_layer_transform
);

  dlg_pkg::cfg_t cfg_r;
  logic          mq_push, mq_full, mq_pop, mq_vld;
  dlg_pkg::mid_t mq_din, mq_dout;
  dlg_pkg::res_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.w   <= dlg_pkg::DIM_BITS'(1920);
      cfg_r.h   <= dlg_pkg::DIM_BITS'(1080);
      cfg_r.rot <= dlg_pkg::ROT_0;
    end else if (cfg_we) begin
      case (cfg_addr)
        dlg_pkg::REG_SCREEN_W:   cfg_r.w   <= cfg_wdata;
        dlg_pkg::REG_SCREEN_H:   cfg_r.h   <= cfg_wdata;
        dlg_pkg::REG_SCREEN_ROT: cfg_r.rot <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  dlg_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .push                (push),
    .full                (full),
    .in_dst_x            (in_dst_x),
    .in_dst_y            (in_dst_y),
    .in_dst_w            (in_dst_w),
    .in_dst_h            (in_dst_h),
    .in_src_x            (in_src_x),
    .in_src_y            (in_src_y),
    .in_src_w            (in_src_w),
    .in_src_h            (in_src_h),
    .in_surface_rotation (in_surface_rotation),
    .in_scale_crop_mode  (in_scale_crop_mode),
    .in_is_display_layer (in_is_display_layer),
    .mq_push             (mq_push),
    .mq_din              (mq_din),
    .mq_full             (mq_full)
  );

  dlg_mq u_mq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .din   (mq_din),
    .full  (mq_full),
    .pop   (mq_pop),
    .vld   (mq_vld),
    .dout  (mq_dout)
  );

  dlg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .mq_vld  (mq_vld),
    .mq_dout (mq_dout),
    .mq_pop  (mq_pop),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign out_dst_x           = head.dst_x;
  assign out_dst_y           = head.dst_y;
  assign out_dst_w           = head.dst_w;
  assign out_dst_h           = head.dst_h;
  assign out_src_x           = head.src_x;
  assign out_src_y           = head.src_y;
  assign out_src_w           = head.src_w;
  assign out_src_h           = head.src_h;
  assign out_layer_transform = head.xform;

endmodule
